// ===== hdl/rrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and constants of the region rectangle table
// Command and status codes, field widths, table depth and sheet limits.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int RowW = 21;
  localparam int ColW = 15;

  localparam int MaxRegions = 64;

  localparam logic [RowW-1:0] RowLimit = 21'd1048576;
  localparam logic [ColW-1:0] ColLimit = 15'd16384;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_FIND_CELL = 3'd1,
    CMD_FIND_EXACT = 3'd2,
    CMD_READ = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_SHIFT_ROWS = 3'd5,
    CMD_SHIFT_COLS = 3'd6,
    CMD_CLEAR = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_BAD_RANGE = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  typedef struct packed {
    logic [RowW-1:0] top;
    logic [ColW-1:0] left;
    logic [RowW-1:0] bottom;
    logic [ColW-1:0] right;
  } rect_t;

  // one shifted interval and whether it survives
  typedef struct packed {
    logic            keep;
    logic [RowW-1:0] lo;
    logic [RowW-1:0] hi;
  } span_t;

endpackage

`default_nettype wire

// ===== hdl/rrt_shift_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_shift_unit: shared interval shift unit
// Moves, clips or drops one interval for a row or column insertion or
// deletion band, saturating at the sheet limit.
// ----------------------------------------------------------------------------
module rrt_shift_unit
  import rrt_pkg::*;
(
  input  wire logic [RowW-1:0] lo_i,
  input  wire logic [RowW-1:0] hi_i,
  input  wire logic [RowW-1:0] from_i,
  input  wire logic [RowW-1:0] amount_i,
  input  wire logic [RowW-1:0] limit_i,
  output rrt_pkg::span_t       span_o
);

  logic signed [23:0] lo, hi, from, delta, band_end, lim;
  logic               drop;

  always_comb begin
    lo       = {3'b000, lo_i};
    hi       = {3'b000, hi_i};
    from     = {3'b000, from_i};
    delta    = {{3{amount_i[RowW-1]}}, amount_i};
    lim      = {3'b000, limit_i};
    band_end = from - delta - 24'sd1;
    drop     = 1'b0;
    if (hi >= from) begin
      if (delta < 0) begin
        if (lo >= from && hi <= band_end) begin
          drop = 1'b1;
        end else begin
          if (lo >= from && lo <= band_end) lo = from;
          if (hi <= band_end) hi = from - 24'sd1;
          else hi = hi + delta;
          if (hi < lo) drop = 1'b1;
          if (lo > band_end) lo = lo + delta;
        end
      end else begin
        if (lo >= from) lo = lo + delta;
        hi = hi + delta;
      end
      if (lo > lim) lo = lim;
      else if (lo < 24'sd1) lo = 24'sd1;
      if (hi > lim) hi = lim;
      else if (hi < 24'sd1) hi = 24'sd1;
    end
    span_o.keep = !drop;
    span_o.lo   = lo[RowW-1:0];
    span_o.hi   = hi[RowW-1:0];
  end

endmodule

`default_nettype wire

// ===== hdl/region_rectangle_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// region_rectangle_table: ordered table of non-overlapping rectangles
// Append, find, read, delete, clear and row/column shift commands.
// ----------------------------------------------------------------------------
// Usage: one command word enters on s_axis, one status word leaves on m_axis.
// s_axis_tready is high only while the sequencer is idle and no result waits.
// Each stored entry is visited through one registered memory read port, first
// read and then compared or written. Clear, a zero or empty shift, a full
// table, a range error, a bad index and an append to an empty table go
// straight to the status word; a read fetches one entry; an append or find
// scans the entries in order; a delete reads entry i and then moves each
// entry behind it down; a shift walks the entries from last to first and
// compacts the entries behind each one that it removes.
// The result word holds in m_axis until taken; no new command is accepted
// while it waits. The next command is accepted at the edge after the one
// that takes the status word. Reset empties the table (entry count to zero);
// stored entries are left undefined and never read before being written.
// ----------------------------------------------------------------------------
module region_rectangle_table
  import rrt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cmd[2:0] first_row[23:3] first_col[38:24] last_row[59:39] last_col[74:60]
  // entry_index[80:75] shift_amount[101:81] shift_start[122:102]
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0] result_index[8:3] top_row[29:9] left_col[44:30]
  // bottom_row[65:45] right_col[80:66] entries_held[87:81]
  output logic [87:0]       m_axis_tdata
);

  localparam int IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int CntW = $clog2(MaxRegions + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_COMPACT, S_SHIFT, S_DONE
  } state_e;

  rect_t mem [MaxRegions];

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] ptr_q;
  logic [CntW-1:0] shift_ptr_q;
  logic            rd_pend_q;
  rect_t           rd_q;
  logic [2:0]      cmd_q;
  rect_t           arg_q;
  logic [5:0]      idx_q;
  logic [RowW-1:0] amt_q;
  logic [RowW-1:0] from_q;
  logic [2:0]      st_q;
  logic [5:0]      ridx_q;
  rect_t           rrect_q;
  logic            from_shift_q;

  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  rect_t           wr_data;
  span_t           span;
  logic [RowW-1:0] su_lo, su_hi, su_lim;

  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    if (cmd_q == CMD_SHIFT_ROWS) begin
      su_lo  = rd_q.top;
      su_hi  = rd_q.bottom;
      su_lim = RowLimit;
    end else begin
      su_lo  = {6'd0, rd_q.left};
      su_hi  = {6'd0, rd_q.right};
      su_lim = {6'd0, ColLimit};
    end
  end

  rrt_shift_unit u_shift (
    .lo_i    (su_lo),
    .hi_i    (su_hi),
    .from_i  (from_q),
    .amount_i(amt_q),
    .limit_i (su_lim),
    .span_o  (span)
  );

  logic hit_cell, hit_exact, hit_ovl;
  always_comb begin
    hit_cell  = rd_q.top <= arg_q.top && arg_q.top <= rd_q.bottom &&
                rd_q.left <= arg_q.left && arg_q.left <= rd_q.right;
    hit_exact = rd_q == arg_q;
    hit_ovl   = rd_q.top <= arg_q.bottom && arg_q.top <= rd_q.bottom &&
                rd_q.left <= arg_q.right && arg_q.left <= rd_q.right;
  end

  rect_t in_rect;
  logic  bad_rng;
  always_comb begin
    in_rect.top    = s_axis_tdata[23:3];
    in_rect.left   = s_axis_tdata[38:24];
    in_rect.bottom = s_axis_tdata[59:39];
    in_rect.right  = s_axis_tdata[74:60];
    bad_rng = in_rect.top < 21'd1 || in_rect.bottom < 21'd1 ||
              in_rect.top > RowLimit || in_rect.bottom > RowLimit ||
              in_rect.left < 15'd1 || in_rect.right < 15'd1 ||
              in_rect.left > ColLimit || in_rect.right > ColLimit ||
              in_rect.bottom < in_rect.top || in_rect.right < in_rect.left ||
              (in_rect.top == in_rect.bottom && in_rect.left == in_rect.right);
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr_q[IdxW-1:0];
    wr_data = rd_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready &&
            s_axis_tdata[2:0] == CMD_APPEND && !bad_rng &&
            count_q < CntW'(MaxRegions) && count_q == '0) begin
          wr_en   = 1'b1;
          wr_addr = count_q[IdxW-1:0];
          wr_data = in_rect;
        end
      end
      S_SCAN, S_READ, S_SHIFT: begin
        rd_en = !rd_pend_q;
        if (state_q == S_SCAN && rd_pend_q && cmd_q == CMD_APPEND &&
            !hit_ovl && ptr_q + 1'b1 == count_q) begin
          wr_en   = 1'b1;
          wr_addr = count_q[IdxW-1:0];
          wr_data = arg_q;
        end
        if (state_q == S_SHIFT && rd_pend_q && span.keep) begin
          wr_en = 1'b1;
          if (cmd_q == CMD_SHIFT_ROWS) begin
            wr_data.top    = span.lo;
            wr_data.bottom = span.hi;
          end else begin
            wr_data.left  = span.lo[ColW-1:0];
            wr_data.right = span.hi[ColW-1:0];
          end
        end
      end
      S_COMPACT: begin
        rd_addr = IdxW'(ptr_q + 1'b1);
        rd_en   = !rd_pend_q && (ptr_q + 1'b1 < count_q);
        wr_en   = rd_pend_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      ptr_q         <= '0;
      shift_ptr_q   <= '0;
      rd_pend_q     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      from_shift_q  <= 1'b0;
      cmd_q         <= '0;
      arg_q         <= '0;
      idx_q         <= '0;
      amt_q         <= '0;
      from_q        <= '0;
      st_q          <= '0;
      ridx_q        <= '0;
      rrect_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
          if (s_axis_tvalid && s_axis_tready) begin
            cmd_q     <= s_axis_tdata[2:0];
            arg_q     <= in_rect;
            idx_q     <= s_axis_tdata[80:75];
            amt_q     <= s_axis_tdata[101:81];
            from_q    <= (s_axis_tdata[122:102] == '0) ? 21'd1 : s_axis_tdata[122:102];
            st_q      <= ST_OK;
            ridx_q    <= '0;
            rrect_q   <= '0;
            ptr_q     <= '0;
            rd_pend_q <= 1'b0;
            from_shift_q <= 1'b0;
            case (s_axis_tdata[2:0])
              CMD_APPEND: begin
                if (count_q >= CntW'(MaxRegions)) begin
                  st_q <= ST_FULL; state_q <= S_DONE;
                end else if (bad_rng) begin
                  st_q <= ST_BAD_RANGE; state_q <= S_DONE;
                end else if (count_q == '0) begin
                  ridx_q  <= '0;
                  rrect_q <= in_rect;
                  count_q <= CntW'(1);
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              CMD_FIND_CELL, CMD_FIND_EXACT: begin
                if (count_q == '0) begin
                  st_q <= ST_NOT_FOUND; state_q <= S_DONE;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              CMD_READ, CMD_DELETE: begin
                if ({1'b0, s_axis_tdata[80:75]} >= 7'(count_q)) begin
                  st_q <= ST_BAD_INDEX; state_q <= S_DONE;
                end else begin
                  ptr_q   <= CntW'(s_axis_tdata[80:75]);
                  state_q <= S_READ;
                end
              end
              CMD_SHIFT_ROWS, CMD_SHIFT_COLS: begin
                if (s_axis_tdata[101:81] == '0 || count_q == '0) begin
                  state_q <= S_DONE;
                end else begin
                  ptr_q   <= count_q - 1'b1;
                  state_q <= S_SHIFT;
                end
              end
              default: begin
                count_q <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            if ((cmd_q == CMD_APPEND && hit_ovl) ||
                (cmd_q == CMD_FIND_CELL && hit_cell) ||
                (cmd_q == CMD_FIND_EXACT && hit_exact)) begin
              ridx_q <= ptr_q[5:0];
              if (cmd_q == CMD_APPEND) st_q <= ST_OVERLAP;
              else rrect_q <= rd_q;
              state_q <= S_DONE;
            end else if (ptr_q + 1'b1 == count_q) begin
              if (cmd_q == CMD_APPEND) begin
                ridx_q  <= count_q[5:0];
                rrect_q <= arg_q;
                count_q <= count_q + 1'b1;
              end else begin
                st_q <= ST_NOT_FOUND;
              end
              state_q <= S_DONE;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
        end
        S_READ: begin
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            ridx_q    <= idx_q;
            rrect_q   <= rd_q;
            state_q   <= (cmd_q == CMD_DELETE) ? S_COMPACT : S_DONE;
          end
        end
        S_COMPACT: begin
          if (ptr_q + 1'b1 >= count_q) begin
            count_q <= count_q - 1'b1;
            if (from_shift_q) begin
              from_shift_q <= 1'b0;
              if (shift_ptr_q == '0) begin
                state_q <= S_DONE;
              end else begin
                ptr_q   <= shift_ptr_q - 1'b1;
                state_q <= S_SHIFT;
              end
            end else begin
              state_q <= S_DONE;
            end
          end else if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            ptr_q     <= ptr_q + 1'b1;
          end
        end
        S_SHIFT: begin
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            if (!span.keep) begin
              shift_ptr_q  <= ptr_q;
              from_shift_q <= 1'b1;
              state_q      <= S_COMPACT;
            end else if (ptr_q == '0) begin
              state_q <= S_DONE;
            end else begin
              ptr_q <= ptr_q - 1'b1;
            end
          end
        end
        S_DONE: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {7'(count_q), rrect_q.right, rrect_q.bottom,
                            rrect_q.left, rrect_q.top, ridx_q, st_q};
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for region_rectangle_table
// Drives command words with random gaps and output stalls and predicts each
// status word from an in-bench copy of the rectangle table. The run covers
// directed edge cases, a full table, a long output hold and random traffic.
// ----------------------------------------------------------------------------
module tb;
  import rrt_pkg::*;

  localparam int Depth = 64;
  localparam int WatchLimit = 200000;

  typedef struct {
    cmd_e            cmd;
    logic [RowW-1:0] r0;
    logic [ColW-1:0] c0;
    logic [RowW-1:0] r1;
    logic [ColW-1:0] c1;
    logic [5:0]      idx;
    logic [20:0]     amt;
    logic [20:0]     start;
  } cmd_word_t;

  typedef struct {
    logic [2:0]      status;
    logic [5:0]      idx;
    logic [RowW-1:0] top;
    logic [ColW-1:0] left;
    logic [RowW-1:0] bottom;
    logic [ColW-1:0] right;
    logic [6:0]      held;
  } status_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [127:0] s_data = '0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [87:0]  m_axis_tdata;

  region_rectangle_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  // table mirror
  longint tops[Depth];
  longint lefts[Depth];
  longint bottoms[Depth];
  longint rights[Depth];
  int     held_count = 0;

  status_word_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void drop_entry(int k);
    for (int j = k; j + 1 < held_count; j++) begin
      tops[j] = tops[j+1];
      lefts[j] = lefts[j+1];
      bottoms[j] = bottoms[j+1];
      rights[j] = rights[j+1];
    end
    if (held_count > 0) held_count--;
  endfunction

  function automatic longint clamp_bound(longint v, longint lim);
    if (v > lim) return lim;
    if (v < 1) return 1;
    return v;
  endfunction

  function automatic void shift_band(bit rows, longint delta, longint from);
    longint lo, hi, band_end, lim;
    int n, i;
    lim = rows ? longint'(RowLimit) : longint'(ColLimit);
    n = held_count;
    if (delta == 0 || n == 0) return;
    if (from < 1) from = 1;
    while (n > 0) begin
      i = n - 1;
      n--;
      lo = rows ? tops[i] : lefts[i];
      hi = rows ? bottoms[i] : rights[i];
      if (hi < from) continue;
      if (delta < 0) begin
        band_end = from - delta - 1;
        if (lo >= from && hi <= band_end) begin
          drop_entry(i);
          continue;
        end
        if (lo >= from && lo <= band_end) lo = from;
        if (hi <= band_end) hi = from - 1;
        else hi = hi + delta;
        if (hi < lo) begin
          drop_entry(i);
          continue;
        end
        if (lo > band_end) lo = lo + delta;
      end else begin
        if (lo >= from) lo = lo + delta;
        hi = hi + delta;
      end
      if (rows) begin
        tops[i] = clamp_bound(lo, lim);
        bottoms[i] = clamp_bound(hi, lim);
      end else begin
        lefts[i] = clamp_bound(lo, lim);
        rights[i] = clamp_bound(hi, lim);
      end
    end
  endfunction

  function automatic void load_rect(ref status_word_t r, input int k);
    r.idx = k[5:0];
    r.top = tops[k][RowW-1:0];
    r.left = lefts[k][ColW-1:0];
    r.bottom = bottoms[k][RowW-1:0];
    r.right = rights[k][ColW-1:0];
  endfunction

  function automatic status_word_t table_step(cmd_word_t w);
    status_word_t r;
    longint r0, c0, r1, c1, amount;
    int i;
    bit hit;
    r = '{default: '0};
    r.status = ST_OK;
    r0 = w.r0;
    c0 = w.c0;
    r1 = w.r1;
    c1 = w.c1;
    amount = $signed(w.amt);
    case (w.cmd)
      CMD_APPEND: begin
        if (held_count >= Depth) begin
          r.status = ST_FULL;
        end else if (r0 < 1 || r1 < 1 || r0 > RowLimit || r1 > RowLimit ||
                     c0 < 1 || c1 < 1 || c0 > ColLimit || c1 > ColLimit ||
                     r1 < r0 || c1 < c0 || (r0 == r1 && c0 == c1)) begin
          r.status = ST_BAD_RANGE;
        end else begin
          for (i = 0; i < held_count; i++)
            if (tops[i] <= r1 && r0 <= bottoms[i] && lefts[i] <= c1 && c0 <= rights[i])
              break;
          if (i < held_count) begin
            r.status = ST_OVERLAP;
            r.idx = i[5:0];
          end else begin
            tops[held_count] = r0;
            lefts[held_count] = c0;
            bottoms[held_count] = r1;
            rights[held_count] = c1;
            load_rect(r, held_count);
            held_count++;
          end
        end
      end
      CMD_FIND_CELL, CMD_FIND_EXACT: begin
        for (i = 0; i < held_count; i++) begin
          if (w.cmd == CMD_FIND_CELL)
            hit = tops[i] <= r0 && r0 <= bottoms[i] && lefts[i] <= c0 && c0 <= rights[i];
          else
            hit = tops[i] == r0 && lefts[i] == c0 && bottoms[i] == r1 && rights[i] == c1;
          if (hit) break;
        end
        if (i >= held_count) r.status = ST_NOT_FOUND;
        else load_rect(r, i);
      end
      CMD_READ, CMD_DELETE: begin
        if (w.idx >= held_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          load_rect(r, w.idx);
          if (w.cmd == CMD_DELETE) drop_entry(w.idx);
        end
      end
      CMD_SHIFT_ROWS: shift_band(1'b1, amount, longint'(w.start));
      CMD_SHIFT_COLS: shift_band(1'b0, amount, longint'(w.start));
      default: held_count = 0;
    endcase
    r.held = held_count[6:0];
    return r;
  endfunction

  task automatic send_word(cmd_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {5'd0, w.start, w.amt, w.idx, w.c1, w.r1, w.c0, w.r0, w.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results = {pending_results, table_step(w)};
    words_sent++;
  endtask

  function automatic cmd_word_t make_word(cmd_e c, longint r0, longint c0, longint r1,
                                          longint c1, int idx = 0, longint amt = 0,
                                          longint start = 1);
    cmd_word_t w;
    w.cmd = c;
    w.r0 = r0[RowW-1:0];
    w.c0 = c0[ColW-1:0];
    w.r1 = r1[RowW-1:0];
    w.c1 = c1[ColW-1:0];
    w.idx = idx[5:0];
    w.amt = amt[20:0];
    w.start = start[20:0];
    return w;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v,
               act_v);
      errors++;
    end
  endfunction

  // output side: check each word, stall at random, hold off on request
  initial begin
    status_word_t e;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_ready) begin
        words_checked++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected status word, expected none, actual %h", $time,
                   m_axis_tdata);
          errors++;
        end else begin
          e = pending_results.pop_front();
          check_field("status", e.status, m_axis_tdata[2:0]);
          check_field("result_index", e.idx, m_axis_tdata[8:3]);
          check_field("top_row", e.top, m_axis_tdata[29:9]);
          check_field("left_col", e.left, m_axis_tdata[44:30]);
          check_field("bottom_row", e.bottom, m_axis_tdata[65:45]);
          check_field("right_col", e.right, m_axis_tdata[80:66]);
          check_field("entries_held", e.held, m_axis_tdata[87:81]);
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
        m_ready <= 1'b1;
      end else if (stall_left > 0) begin
        m_ready <= 1'b0;
        stall_left--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, WatchLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_word(make_word(CMD_READ, 1, 1, 1, 1, 0));
    send_word(make_word(CMD_SHIFT_ROWS, 1, 1, 1, 1, 0, 5, 1));
    send_word(make_word(CMD_CLEAR, 1, 1, 1, 1));
    send_word(make_word(CMD_APPEND, 1, 1, 1, 2));
    send_word(make_word(CMD_APPEND, 1048575, 16383, 1048576, 16384));
    send_word(make_word(CMD_APPEND, 10, 10, 10, 10));
    send_word(make_word(CMD_APPEND, 20, 5, 19, 6));
    send_word(make_word(CMD_APPEND, 20, 6, 21, 5));
    send_word(make_word(CMD_APPEND, 0, 3, 4, 4));
    send_word(make_word(CMD_APPEND, 3, 3, 4, 16385));
    send_word(make_word(CMD_APPEND, 1, 2, 3, 3));
    send_word(make_word(CMD_APPEND, 5, 5, 9, 9));
    send_word(make_word(CMD_FIND_CELL, 7, 8, 0, 0));
    send_word(make_word(CMD_FIND_CELL, 0, 0, 0, 0));
    send_word(make_word(CMD_FIND_EXACT, 1048575, 16383, 1048576, 16384));
    send_word(make_word(CMD_FIND_EXACT, 5, 5, 9, 8));
    send_word(make_word(CMD_READ, 0, 0, 0, 0, 2));
    send_word(make_word(CMD_READ, 0, 0, 0, 0, 63));
    send_word(make_word(CMD_SHIFT_ROWS, 0, 0, 0, 0, 0, 3, 0));
    send_word(make_word(CMD_SHIFT_COLS, 0, 0, 0, 0, 0, -2, 6));
    send_word(make_word(CMD_SHIFT_ROWS, 0, 0, 0, 0, 0, 0, 2));
    send_word(make_word(CMD_SHIFT_ROWS, 0, 0, 0, 0, 0, 1048575, 2));
    send_word(make_word(CMD_SHIFT_COLS, 0, 0, 0, 0, 0, -1048576, 1));
    send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic test_full_table();
    for (int k = 0; k < Depth + 2; k++)
      send_word(make_word(CMD_APPEND, 3 * k + 1, 1, 3 * k + 2, 2));
    send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 63));
    send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 63));
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int k = 0; k < 12; k++)
      send_word(make_word(CMD_READ, 0, 0, 0, 0, $urandom_range(0, 70)));
    no_idle = 1'b0;
  endtask

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int sel, k, area;
    longint r0, c0;
    w = make_word(CMD_APPEND, 0, 0, 0, 0, $urandom_range(0, 63), 0, 1);
    area = $urandom_range(0, 99);
    if (area < 80) begin
      r0 = $urandom_range(1, 60);
      c0 = $urandom_range(1, 30);
    end else begin
      r0 = $urandom_range(1048530, 1048576);
      c0 = $urandom_range(16350, 16384);
    end
    w.r0 = r0[RowW-1:0];
    w.c0 = c0[ColW-1:0];
    w.r1 = RowW'(r0 + $urandom_range(0, 4));
    w.c1 = ColW'(c0 + $urandom_range(0, 3));
    if ($urandom_range(0, 19) == 0) begin
      w.r0 = RowW'($urandom);
      w.c0 = ColW'($urandom);
      w.r1 = RowW'($urandom);
      w.c1 = ColW'($urandom);
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) w.cmd = CMD_APPEND;
    else if (sel < 50) w.cmd = CMD_FIND_CELL;
    else if (sel < 60) w.cmd = CMD_FIND_EXACT;
    else if (sel < 70) w.cmd = CMD_READ;
    else if (sel < 80) w.cmd = CMD_DELETE;
    else if (sel < 89) w.cmd = CMD_SHIFT_ROWS;
    else if (sel < 98) w.cmd = CMD_SHIFT_COLS;
    else w.cmd = CMD_CLEAR;
    if (held_count > 0 && $urandom_range(0, 1)) begin
      k = $urandom_range(0, held_count - 1);
      if (w.cmd == CMD_FIND_EXACT) begin
        w.r0 = tops[k][RowW-1:0];
        w.c0 = lefts[k][ColW-1:0];
        w.r1 = bottoms[k][RowW-1:0];
        w.c1 = rights[k][ColW-1:0];
      end else if (w.cmd == CMD_FIND_CELL) begin
        w.r0 = bottoms[k][RowW-1:0];
        w.c0 = lefts[k][ColW-1:0];
      end else begin
        w.idx = k[5:0];
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 7) w.amt = 21'($signed($urandom_range(0, 20)) - 10);
    else if (sel < 9) w.amt = 21'($signed($urandom_range(0, 2000000)) - 1000000);
    else w.amt = 21'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 7) w.start = 21'($urandom_range(1, 60));
    else if (sel < 8) w.start = '0;
    else if (sel < 9) w.start = 21'($urandom_range(16340, 16384));
    else w.start = 21'($urandom);
    return w;
  endfunction

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 100) no_idle = 1'b1;
      if (n % 150 == 130) no_idle = 1'b0;
      send_word(random_word());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_output_hold();
    test_random(590);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 10) @(posedge clk_i);
    $display("Ran %0d command words, %0d status words checked, %0d errors.", words_sent,
             words_checked, errors);
    $display("Covered append checks, lookups, reads, deletes, shifts, clears and stalls.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
